@@ hdl/utf8vc_pkg.sv @@
// utf8vc_pkg: types, codes and constants for the utf-8 validate and count unit
// used by hdl/utf8_validate_and_count_unit.sv, depends on nothing

package utf8vc_pkg;

   // width of the internal code point counter, it saturates at all ones
   localparam int COUNT_WIDTH     = 16;
   localparam int RSP_COUNT_WIDTH = 16;
   localparam int RSP_COUNT_MAX   = (1 << RSP_COUNT_WIDTH) - 1;
   localparam int WIDE_COUNT_WIDTH =
      (COUNT_WIDTH > RSP_COUNT_WIDTH) ? COUNT_WIDTH : RSP_COUNT_WIDTH;

   // error kinds
   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_LEAD  = 2'd1;
   localparam logic [1:0] ERR_CONT  = 2'd2;
   localparam logic [1:0] ERR_TRUNC = 2'd3;

   // narrowed ranges for the first continuation byte
   localparam logic [2:0] RULE_NONE  = 3'd0;
   localparam logic [2:0] RULE_A0_BF = 3'd1;
   localparam logic [2:0] RULE_80_9F = 3'd2;
   localparam logic [2:0] RULE_90_BF = 3'd3;
   localparam logic [2:0] RULE_80_8F = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic                       valid_res;
      logic [1:0]                 error_kind;
      logic [RSP_COUNT_WIDTH-1:0] codepoint_count;
   } rsp_type;

endpackage

@@ hdl/utf8_validate_and_count_unit.sv @@
// utf8_validate_and_count_unit: streaming utf-8 checker and code point counter
// depends on hdl/utf8vc_pkg.sv

// One byte of a string is taken per transfer on req_, the final byte flagged
// by last. Every byte is checked in the cycle it arrives: the next parser
// state is computed in one short combinational pass from the byte and the
// state registers, so a byte is accepted every clock while req_ready is high.
// Only a last byte yields a result; it lands in the rsp_ output register in
// the cycle after its transfer, carrying validity, the first error seen (bad
// lead, bad continuation, truncated) and the saturated count of code points
// started. The parser state then clears for the next string.
// req_ready stays high while the output register is empty or being taken.

module utf8_validate_and_count_unit
   import utf8vc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [1:0]             pend_ff, pend_in;
   logic [2:0]             rule_ff, rule_in;
   logic [1:0]             err_ff, err_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                        req_xfer;
   logic [7:0]                  b;
   logic                        range_ok;
   logic                        cont_ok;
   logic                        take_lead;
   logic [1:0]                  lead_pend;
   logic [2:0]                  lead_rule;
   logic                        lead_bad;
   logic [1:0]                  err_step;
   logic [1:0]                  err_final;
   logic [WIDE_COUNT_WIDTH-1:0] cnt_wide;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign b         = req_data.data_byte;

   // narrowed range check for the first continuation
   always_comb begin
      unique case (rule_ff)
         RULE_A0_BF: range_ok = (b >= 8'hA0) && (b <= 8'hBF);
         RULE_80_9F: range_ok = (b <= 8'h9F);
         RULE_90_BF: range_ok = (b >= 8'h90) && (b <= 8'hBF);
         RULE_80_8F: range_ok = (b <= 8'h8F);
         default:    range_ok = 1'b1;
      endcase
   end

   assign cont_ok   = ((b & 8'hC0) == 8'h80) && range_ok;
   assign take_lead = (pend_ff == 2'd0) || !cont_ok;

   // lead byte decode
   always_comb begin
      lead_pend = 2'd0;
      lead_rule = RULE_NONE;
      lead_bad  = 1'b0;
      priority if (b < 8'h80) begin
         lead_pend = 2'd0;
      end else if ((b >= 8'hC2) && (b <= 8'hDF)) begin
         lead_pend = 2'd1;
      end else if ((b & 8'hF0) == 8'hE0) begin
         lead_pend = 2'd2;
         if (b == 8'hE0) lead_rule = RULE_A0_BF;
         else if (b == 8'hED) lead_rule = RULE_80_9F;
      end else if (((b & 8'hF8) == 8'hF0) && (b <= 8'hF4)) begin
         lead_pend = 2'd3;
         if (b == 8'hF0) lead_rule = RULE_90_BF;
         else if (b == 8'hF4) lead_rule = RULE_80_8F;
      end else begin
         lead_bad = 1'b1;
      end
   end

   always_comb begin
      err_step = err_ff;
      if ((pend_ff != 2'd0) && !cont_ok && (err_step == ERR_NONE)) begin
         err_step = ERR_CONT;
      end
      if (take_lead) begin
         pend_in = lead_pend;
         rule_in = lead_rule;
         cnt_in  = (cnt_ff == '1) ? cnt_ff : cnt_ff + COUNT_WIDTH'(1);
         if (lead_bad && (err_step == ERR_NONE)) begin
            err_step = ERR_LEAD;
         end
      end else begin
         pend_in = pend_ff - 2'd1;
         rule_in = RULE_NONE;
         cnt_in  = cnt_ff;
      end
      err_in    = err_step;
      err_final = err_step;
      if ((pend_in != 2'd0) && (err_final == ERR_NONE)) begin
         err_final = ERR_TRUNC;
      end
   end

   assign cnt_wide = WIDE_COUNT_WIDTH'(cnt_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_xfer && req_data.last) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.valid_res       = (err_final == ERR_NONE);
         rsp_data_in.error_kind      = err_final;
         rsp_data_in.codepoint_count =
            (cnt_wide > WIDE_COUNT_WIDTH'(RSP_COUNT_MAX)) ? '1
                                                          : cnt_wide[RSP_COUNT_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 2'd0;
         rule_ff      <= RULE_NONE;
         err_ff       <= ERR_NONE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            if (req_data.last) begin
               pend_ff <= 2'd0;
               rule_ff <= RULE_NONE;
               err_ff  <= ERR_NONE;
               cnt_ff  <= '0;
            end else begin
               pend_ff <= pend_in;
               rule_ff <= rule_in;
               err_ff  <= err_in;
               cnt_ff  <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // validity flag agrees with the error kind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.valid_res == (rsp_data.error_kind == ERR_NONE)))
      else $error("valid_res disagrees with error_kind");

   // a string end clears the parser
   assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_data.last) |=>
         (pend_ff == 2'd0) && (err_ff == ERR_NONE) && (cnt_ff == '0))
      else $error("state not cleared after last byte");

   // a new result only follows a last byte transfer
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_xfer && req_data.last))
      else $error("result without last byte");

   // a narrowed range is only armed with continuations pending
   assert property (@(posedge clock) disable iff (reset)
      (rule_ff != RULE_NONE) |-> (pend_ff != 2'd0))
      else $error("range rule armed with nothing pending");

endmodule
